// ===== rtl/mac_learning_table_core_defines.svh =====
// Assertion helpers shared by the table RTL.
`ifndef MAC_LEARNING_TABLE_CORE_DEFINES_SVH
`define MAC_LEARNING_TABLE_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define MLT_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mac table check failed");

// Next-cycle implication, checked on every rising edge out of reset.
`define MLT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mac table check failed");

`endif

// ===== rtl/mlt_pkg.sv =====
`timescale 1ns / 1ps
package mlt_pkg;

	localparam int unsigned MacW    = 48;
	localparam int unsigned PortW   = 8;
	localparam int unsigned StampW  = 32;
	localparam int unsigned HashW   = 16;
	localparam int unsigned CfgIdxW = 2;

	localparam int unsigned DefBuckets = 256;
	localparam int unsigned DefWays    = 4;
	localparam int unsigned DefPorts   = 256;

	typedef enum logic [2:0] {
		CMD_LEARN       = 3'd0,
		CMD_LOOKUP      = 3'd1,
		CMD_ADD_LOCAL   = 3'd2,
		CMD_REMOVE_PORT = 3'd3,
		CMD_TICK        = 3'd4,
		CMD_SWEEP       = 3'd5
	} cmd_t;

	typedef enum logic [2:0] {
		STAT_OK      = 3'd0,
		STAT_INVALID = 3'd1,
		STAT_FULL    = 3'd2,
		STAT_OWN     = 3'd3,
		STAT_IGNORED = 3'd4
	} stat_t;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_AGEING    = 2'd0,
		CFG_FWD_DELAY = 2'd1,
		CFG_TOPO      = 2'd2
	} cfg_idx_t;

	typedef enum logic [2:0] {
		S_CLEAR, S_IDLE, S_HASH, S_MOD, S_READ, S_CHECK, S_WALK, S_RESP
	} state_t;

	typedef struct packed {
		logic              valid;
		logic              loc_flag;
		logic [PortW-1:0]  port;
		logic [StampW-1:0] stamp;
		logic [MacW-1:0]   mac;
	} way_t;

	typedef struct packed {
		stat_t            status;
		logic             found_local;
		logic [PortW-1:0] found_port;
		logic             hit;
	} res_t;

	// XOR-fold the address down to the hash width
	function automatic logic [HashW-1:0] fold_mac(input logic [MacW-1:0] mac);
		return mac[15:0] ^ mac[31:16] ^ mac[47:32];
	endfunction

	// Dynamic entry is stale once stamp + hold has been reached
	function automatic logic is_expired(input way_t w, input logic [StampW-1:0] hold,
			input logic [StampW-1:0] now);
		logic [StampW-1:0] d;
		d = w.stamp + hold - now;
		return !w.loc_flag && ((d == '0) || d[StampW-1]);
	endfunction

endpackage

// ===== rtl/mlt_row_ram.sv =====
`timescale 1ns / 1ps
module mlt_row_ram #(
	parameter int unsigned Depth = 256,
	parameter int unsigned Width = 8
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [$clog2(Depth > 1 ? Depth : 2)-1:0] waddr,
	input  logic [Width-1:0]                         wdata,
	input  logic                                    re,
	input  logic [$clog2(Depth > 1 ? Depth : 2)-1:0] raddr,
	output logic [Width-1:0]                         rdata
);
	logic [Width-1:0] mem [Depth];

	// Write one row
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== rtl/mac_learning_table_core.sv =====
`timescale 1ns / 1ps
// MAC learning table: hashed, set-associative store of addresses with port,
// local flag and age stamp. One command beat in, one result beat out.
// Input beat: s_axis_tuser carries the command, s_axis_tdata the address
// and port. Output beat: hit, found port, local flag and status.
// Configuration writes (hold times, topology change) go through the cfg
// channel, which is always ready; write them only while the table is idle.
// learn, lookup and add_local pass from input beat to output beat through
// hash, reciprocal modulo in two multiply steps, bucket read and
// read-modify-write of the bucket row. tick, unknown commands and a
// remove_port with an out-of-range port go straight to the response.
// remove_port and sweep walk every bucket row through the row memory, one
// row read and one written back per cycle.
// One command is worked on at a time; a new beat is taken as soon as the
// previous result sits in the output register, even if it is not yet taken.
// After reset the block clears the row memory, one bucket per cycle, with
// s_axis_tready low. A stalled output holds its beat and the block waits
// with its next result until the register frees up.
module mac_learning_table_core #(
	parameter int unsigned BUCKETS = mlt_pkg::DefBuckets,
	parameter int unsigned WAYS    = mlt_pkg::DefWays,
	parameter int unsigned PORTS   = mlt_pkg::DefPorts
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [55:0]                 s_axis_tdata,  // address[47:0], port_id[55:48]
	input  logic [2:0]                  s_axis_tuser,  // command[2:0]
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [15:0]                 m_axis_tdata,  // hit[0], found_port[8:1],
	                                                   // found_local[9], status[12:10]
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [mlt_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [31:0]                 cfg_data
);
	import mlt_pkg::*;
	`include "mac_learning_table_core_defines.svh"

	localparam int unsigned BW      = $clog2(BUCKETS > 1 ? BUCKETS : 2);
	localparam int unsigned WIdxW   = $clog2(WAYS > 1 ? WAYS : 2);
	localparam int unsigned WayBits = $bits(way_t);
	localparam int unsigned RowW    = WAYS * WayBits;
	localparam logic [32:0] RecipM  =
		33'(((64'd1 << 32) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS));

	state_t state_q, state_d;
	cmd_t   cmd_q;
	logic [MacW-1:0]   mac_q;
	logic [PortW-1:0]  port_q;
	logic [HashW-1:0]  hash_q;
	logic [48:0]       prod_q;
	logic [HashW-1:0]  qb_q;
	logic [BW-1:0]     bucket_q;
	logic [BW:0]       clr_q;
	logic [BW:0]       walk_q;
	logic              wb_s1;
	logic [BW-1:0]     wb_addr_s1;
	logic [StampW-1:0] now_q, ageing_q, fwd_q;
	logic              topo_q;
	res_t              res_q, out_q;
	logic              out_valid_q;

	logic              accept, out_free, port_bad, mac_bad;
	logic [StampW-1:0] hold;
	logic [HashW-1:0]  rem;
	way_t [WAYS-1:0]   rd_row, chk_row, walk_row;
	logic [RowW-1:0]   rd_data, wr_data;
	logic              we, re, chk_we;
	logic [BW-1:0]     waddr, raddr;
	logic              found, has_free;
	logic [WIdxW-1:0]  hit_way, free_way;
	way_t              mw, nw;
	res_t              chk_res;
	stat_t             in_stat;
	logic [MacW-1:0]   in_mac;
	logic [PortW-1:0]  in_port;

	assign in_mac        = s_axis_tdata[47:0];
	assign in_port       = s_axis_tdata[55:48];
	assign s_axis_tready = (state_q == S_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;
	assign cfg_ready     = 1'b1;
	assign hold          = topo_q ? fwd_q : ageing_q;
	assign port_bad      = ({3'b0, port_q} >= 11'(PORTS));
	assign mac_bad       = (mac_q == '0) || mac_q[40];
	assign rem           = hash_q - qb_q;
	assign rd_row        = rd_data;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'b0, out_q};

	mlt_row_ram #(.Depth(BUCKETS), .Width(RowW)) u_rows (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wr_data),
		.re    (re),
		.raddr (raddr),
		.rdata (rd_data)
	);

	// Search the bucket row: first matching way and first free way
	always_comb begin
		found    = 1'b0;
		has_free = 1'b0;
		hit_way  = '0;
		free_way = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (rd_row[w].valid && rd_row[w].mac == mac_q) begin
				found   = 1'b1;
				hit_way = WIdxW'(w);
			end
			if (!rd_row[w].valid) begin
				has_free = 1'b1;
				free_way = WIdxW'(w);
			end
		end
		mw = rd_row[hit_way];
	end

	// Check the bucket row for learn, lookup and add_local; learn and add_local may modify it
	always_comb begin
		chk_row  = rd_row;
		chk_we   = 1'b0;
		chk_res  = '{status: STAT_OK, found_local: 1'b0, found_port: '0, hit: 1'b0};
		nw       = '{valid: 1'b1, loc_flag: 1'b0, port: port_q, stamp: now_q, mac: mac_q};
		case (cmd_q)
			CMD_LEARN: begin
				if (port_bad || hold == '0) begin
					chk_res.status = STAT_IGNORED;
				end else if (found) begin
					if (mw.loc_flag) begin
						chk_res.status = STAT_OWN;
					end else begin
						chk_row[hit_way].port  = port_q;
						chk_row[hit_way].stamp = now_q;
						chk_we = 1'b1;
					end
				end else if (has_free) begin
					chk_row[free_way] = nw;
					chk_we = 1'b1;
				end else begin
					chk_res.status = STAT_FULL;
				end
			end
			CMD_LOOKUP: begin
				if (found && !is_expired(mw, hold, now_q)) begin
					chk_res.hit         = 1'b1;
					chk_res.found_port  = mw.port;
					chk_res.found_local = mw.loc_flag;
				end
			end
			CMD_ADD_LOCAL: begin
				nw.loc_flag = 1'b1;
				if (port_bad) begin
					chk_res.status = STAT_IGNORED;
				end else if (mac_bad) begin
					chk_res.status = STAT_INVALID;
				end else if (found) begin
					if (!mw.loc_flag) begin
						chk_row[hit_way] = nw;
						chk_we = 1'b1;
					end
				end else if (has_free) begin
					chk_row[free_way] = nw;
					chk_we = 1'b1;
				end else begin
					chk_res.status = STAT_FULL;
				end
			end
			default: begin
				chk_res.status = STAT_IGNORED;
			end
		endcase
	end

	// Drop entries during a remove_port or sweep walk
	always_comb begin
		walk_row = rd_row;
		for (int w = 0; w < WAYS; w++) begin
			if (cmd_q == CMD_REMOVE_PORT) begin
				if (rd_row[w].valid && rd_row[w].port == port_q) begin
					walk_row[w].valid = 1'b0;
				end
			end else if (rd_row[w].valid && is_expired(rd_row[w], hold, now_q)) begin
				walk_row[w].valid = 1'b0;
			end
		end
	end

	// Memory port control
	always_comb begin
		we      = 1'b0;
		waddr   = bucket_q;
		wr_data = chk_row;
		re      = 1'b0;
		raddr   = rem[BW-1:0];
		if (state_q == S_CLEAR) begin
			we      = 1'b1;
			waddr   = clr_q[BW-1:0];
			wr_data = '0;
		end else if (wb_s1) begin
			we      = 1'b1;
			waddr   = wb_addr_s1;
			wr_data = walk_row;
		end else if (state_q == S_CHECK) begin
			we = chk_we;
		end
		if (state_q == S_READ) begin
			re = 1'b1;
		end else if (state_q == S_WALK) begin
			re    = (walk_q < (BW + 1)'(BUCKETS));
			raddr = walk_q[BW-1:0];
		end
	end

	// Status set at input for commands that skip the bucket check
	always_comb begin
		in_stat = STAT_OK;
		case (cmd_t'(s_axis_tuser))
			CMD_LEARN, CMD_LOOKUP, CMD_ADD_LOCAL, CMD_TICK, CMD_SWEEP: ;
			CMD_REMOVE_PORT: begin
				if ({3'b0, in_port} >= 11'(PORTS)) begin
					in_stat = STAT_IGNORED;
				end
			end
			default: in_stat = STAT_IGNORED;
		endcase
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (clr_q == (BW + 1)'(BUCKETS - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					case (cmd_t'(s_axis_tuser))
						CMD_LEARN, CMD_LOOKUP, CMD_ADD_LOCAL: state_d = S_HASH;
						CMD_REMOVE_PORT: begin
							if ({3'b0, in_port} >= 11'(PORTS)) begin
								state_d = S_RESP;
							end else begin
								state_d = S_WALK;
							end
						end
						CMD_SWEEP: state_d = S_WALK;
						default:   state_d = S_RESP;
					endcase
				end
			end
			S_HASH:  state_d = S_MOD;
			S_MOD:   state_d = S_READ;
			S_READ:  state_d = S_CHECK;
			S_CHECK: state_d = S_RESP;
			S_WALK: begin
				if (walk_q == (BW + 1)'(BUCKETS) && !wb_s1) begin
					state_d = S_RESP;
				end
			end
			S_RESP: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Control counters, time base and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			walk_q      <= '0;
			wb_s1       <= 1'b0;
			now_q       <= '0;
			ageing_q    <= 32'd300;
			fwd_q       <= 32'd15;
			topo_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (accept) begin
				walk_q <= '0;
				if (cmd_t'(s_axis_tuser) == CMD_TICK) begin
					now_q <= now_q + 1'b1;
				end
			end
			if (state_q == S_WALK && walk_q < (BW + 1)'(BUCKETS)) begin
				walk_q <= walk_q + 1'b1;
				wb_s1  <= 1'b1;
			end else begin
				wb_s1 <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_idx_t'(cfg_index))
					CFG_AGEING:    ageing_q <= cfg_data;
					CFG_FWD_DELAY: fwd_q    <= cfg_data;
					CFG_TOPO:      topo_q   <= cfg_data[0];
					default:       ;
				endcase
			end
			if (state_q == S_RESP && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Command payload, hash pipeline and result
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= cmd_t'(s_axis_tuser);
			mac_q  <= in_mac;
			port_q <= in_port;
			hash_q <= fold_mac(in_mac);
			res_q  <= '{status: in_stat, found_local: 1'b0, found_port: '0, hit: 1'b0};
		end
		prod_q <= 49'(hash_q) * 49'(RecipM);
		qb_q   <= HashW'(prod_q[47:32] * 17'(BUCKETS));
		if (state_q == S_READ) begin
			bucket_q <= rem[BW-1:0];
		end
		if (state_q == S_CHECK) begin
			res_q <= chk_res;
		end
		if (state_q == S_WALK && walk_q < (BW + 1)'(BUCKETS)) begin
			wb_addr_s1 <= walk_q[BW-1:0];
		end
		if (state_q == S_RESP && out_free) begin
			out_q <= res_q;
		end
	end

	`MLT_ASSERT_NEXT(a_leave_idle, accept, state_q != S_IDLE)
	`MLT_ASSERT_IMPL(a_no_input_while_clear, state_q == S_CLEAR, !s_axis_tready)
	`MLT_ASSERT_IMPL(a_walk_rows_apart, wb_s1 && re, waddr != raddr)
	`MLT_ASSERT_IMPL(a_hit_is_ok, m_axis_tvalid && m_axis_tdata[0], m_axis_tdata[12:10] == STAT_OK)
endmodule

// ===== sim/mac_table_checker.sv =====
`timescale 1ns / 1ps
module mac_table_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [55:0] s_axis_tdata,
	input  logic [2:0]  s_axis_tuser,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [15:0] m_axis_tdata,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output int          fail_count,
	output int          pending
);
	import mlt_pkg::*;

	localparam int NB = 256;
	localparam int NW = 4;
	localparam int NP = 256;

	// shadow table
	logic        tv_valid [NB*NW];
	logic [47:0] tv_mac   [NB*NW];
	logic [7:0]  tv_port  [NB*NW];
	logic        tv_local [NB*NW];
	logic [31:0] tv_stamp [NB*NW];
	logic [31:0] now_ticks;
	logic [31:0] age_time, fwd_delay;
	logic        topo;

	logic [12:0] expected_results [$];

	assign pending = expected_results.size();

	function automatic logic [31:0] hold_now();
		return topo ? fwd_delay : age_time;
	endfunction

	function automatic logic stale(int i);
		logic [31:0] d;
		if (tv_local[i])
			return 1'b0;
		d = tv_stamp[i] + hold_now() - now_ticks;
		return d == 32'd0 || d[31];
	endfunction

	function automatic int find_mac(int base, logic [47:0] mac);
		for (int w = 0; w < NW; w++)
			if (tv_valid[base+w] && tv_mac[base+w] == mac)
				return base + w;
		return -1;
	endfunction

	function automatic int find_free(int base);
		for (int w = 0; w < NW; w++)
			if (!tv_valid[base+w])
				return base + w;
		return -1;
	endfunction

	task automatic put(int i, logic [47:0] mac, logic [7:0] port, logic loc);
		tv_valid[i] = 1'b1;
		tv_mac[i]   = mac;
		tv_port[i]  = port;
		tv_local[i] = loc;
		tv_stamp[i] = now_ticks;
	endtask

	// compute the expected response for one command beat
	task automatic predict_table(logic [2:0] cmd, logic [47:0] mac, logic [7:0] port);
		logic [15:0] h;
		int base, s;
		logic hit, floc;
		logic [7:0] fport;
		stat_t st;
		h = mac[15:0] ^ mac[31:16] ^ mac[47:32];
		base = (int'(h) % NB) * NW;
		hit = 0; floc = 0; fport = 0; st = STAT_OK;
		case (cmd)
		CMD_LEARN: begin
			if (int'(port) >= NP || hold_now() == 0)
				st = STAT_IGNORED;
			else begin
				s = find_mac(base, mac);
				if (s >= 0) begin
					if (tv_local[s])
						st = STAT_OWN;
					else begin
						tv_port[s] = port;
						tv_stamp[s] = now_ticks;
					end
				end else begin
					s = find_free(base);
					if (s < 0)
						st = STAT_FULL;
					else
						put(s, mac, port, 1'b0);
				end
			end
		end
		CMD_LOOKUP: begin
			s = find_mac(base, mac);
			if (s >= 0 && !stale(s)) begin
				hit = 1;
				fport = tv_port[s];
				floc = tv_local[s];
			end
		end
		CMD_ADD_LOCAL: begin
			if (int'(port) >= NP)
				st = STAT_IGNORED;
			else if (mac == 48'd0 || mac[40])
				st = STAT_INVALID;
			else begin
				s = find_mac(base, mac);
				if (s >= 0) begin
					if (!tv_local[s])
						put(s, mac, port, 1'b1);
				end else begin
					s = find_free(base);
					if (s < 0)
						st = STAT_FULL;
					else
						put(s, mac, port, 1'b1);
				end
			end
		end
		CMD_REMOVE_PORT: begin
			if (int'(port) >= NP)
				st = STAT_IGNORED;
			else
				for (int i = 0; i < NB*NW; i++)
					if (tv_valid[i] && tv_port[i] == port)
						tv_valid[i] = 1'b0;
		end
		CMD_TICK: now_ticks = now_ticks + 1;
		CMD_SWEEP: begin
			for (int i = 0; i < NB*NW; i++)
				if (tv_valid[i] && stale(i))
					tv_valid[i] = 1'b0;
		end
		default: st = STAT_IGNORED;
		endcase
		expected_results.push_back({st, floc, fport, hit});
	endtask

	// watch the channels, predict on input beats, compare on output beats
	always @(posedge clk or negedge arst_n) begin
		logic [12:0] want;
		if (!arst_n) begin
			for (int i = 0; i < NB*NW; i++)
				tv_valid[i] = 1'b0;
			now_ticks = 0;
			age_time = 300;
			fwd_delay = 15;
			topo = 0;
			expected_results.delete();
			fail_count = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				case (cfg_index)
				CFG_AGEING:    age_time = cfg_data;
				CFG_FWD_DELAY: fwd_delay = cfg_data;
				CFG_TOPO:      topo = cfg_data[0];
				default: ;
				endcase
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_results.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result beat %h", m_axis_tdata);
				end else begin
					want = expected_results.pop_front();
					if (m_axis_tdata[12:0] !== want || m_axis_tdata[15:13] !== 3'd0) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: hit %b/%b port %h/%h local %b/%b status %0d/%0d",
								want[0], m_axis_tdata[0], want[8:1], m_axis_tdata[8:1],
								want[9], m_axis_tdata[9], want[12:10], m_axis_tdata[12:10]);
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				predict_table(s_axis_tuser, s_axis_tdata[47:0], s_axis_tdata[55:48]);
		end
	end
endmodule

// ===== sim/tb_mac_learning_table_core.sv =====
`timescale 1ns / 1ps
module tb_mac_learning_table_core;
	import mlt_pkg::*;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_axis_tvalid = 0;
	logic        s_axis_tready;
	logic [55:0] s_axis_tdata = '0;
	logic [2:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 0;
	logic [15:0] m_axis_tdata;
	logic        cfg_valid = 0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;
	int          fail_count, pending;

	// receiver behavior: 0 random, 1 never stall; long hold-offs come from hold_cycles
	int rx_mode = 0;
	int hold_cycles = 0;
	int tx_quiet = 0;

	// small pool so addresses collide into buckets and repeat
	logic [47:0] mac_pool [24];

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	mac_learning_table_core u_dut (.*);

	mac_table_checker u_chk (.*);

	// receiver ready
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			m_axis_tready <= 0;
		end else if (rx_mode == 1)
			m_axis_tready <= 1;
		else
			m_axis_tready <= $urandom_range(99) >= 7;
	end

	task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	// offer one beat; valid stays up into the next send or drain
	task automatic send_cmd(logic [2:0] cmd, logic [47:0] mac, logic [7:0] port);
		while (tx_quiet == 0 && $urandom_range(99) < 7) begin
			s_axis_tvalid <= 0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tuser <= cmd;
		s_axis_tdata <= {port, mac};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic drain();
		int guard;
		guard = 0;
		s_axis_tvalid <= 0;
		while (pending != 0 && guard < 100000) begin
			@(posedge clk);
			guard++;
		end
		repeat (300) @(posedge clk);
	endtask

	function automatic logic [47:0] pick_mac();
		case ($urandom_range(9))
		0: return {$urandom, $urandom} & 48'hFFFF_FFFF_FFFF;
		1: return {$urandom_range(3), 8'h00, 32'd0} | 48'd0;
		default: return mac_pool[$urandom_range(23)];
		endcase
	endfunction

	task automatic random_phase(int count);
		int r;
		logic [2:0] cmd;
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(99);
			if (r < 30) cmd = CMD_LEARN;
			else if (r < 60) cmd = CMD_LOOKUP;
			else if (r < 70) cmd = CMD_ADD_LOCAL;
			else if (r < 74) cmd = CMD_REMOVE_PORT;
			else if (r < 90) cmd = CMD_TICK;
			else if (r < 95) cmd = CMD_SWEEP;
			else cmd = 3'($urandom_range(7));
			send_cmd(cmd, pick_mac(),
				($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(3)));
		end
	endtask

	initial begin
		// pool: unicast base addresses; a few share a bucket (same fold)
		for (int i = 0; i < 24; i++)
			mac_pool[i] = {$urandom, $urandom} & 48'hFEFF_FFFF_FFFF;
		for (int i = 0; i < 6; i++)
			mac_pool[i] = {16'(i), 16'(i), 16'h0012};
		mac_pool[6] = 48'hFFFF_FFFF_FFFF;
		mac_pool[7] = 48'h0100_0000_0000;
		repeat (9) @(posedge clk);
		arst_n <= 1;

		// directed: full bucket, own address, invalid, removal
		for (int i = 0; i < 6; i++)
			send_cmd(CMD_LEARN, mac_pool[i], 8'(i));
		send_cmd(CMD_ADD_LOCAL, mac_pool[0], 8'd9);
		send_cmd(CMD_ADD_LOCAL, mac_pool[0], 8'd9);
		send_cmd(CMD_LEARN, mac_pool[0], 8'd3);
		send_cmd(CMD_ADD_LOCAL, 48'd0, 8'd1);
		send_cmd(CMD_ADD_LOCAL, mac_pool[7], 8'd1);
		send_cmd(CMD_ADD_LOCAL, mac_pool[5], 8'd1);
		send_cmd(CMD_LEARN, mac_pool[6], 8'hFF);
		send_cmd(CMD_LOOKUP, mac_pool[6], 8'd0);
		send_cmd(CMD_LOOKUP, mac_pool[0], 8'd0);
		send_cmd(CMD_LOOKUP, mac_pool[1], 8'd0);
		send_cmd(3'd6, mac_pool[1], 8'd0);
		send_cmd(3'd7, mac_pool[1], 8'd0);
		send_cmd(CMD_REMOVE_PORT, 48'd0, 8'd9);
		send_cmd(CMD_SWEEP, 48'd0, 8'd0);
		drain();

		// short hold with topology change: learned entries expire fast
		write_reg(CFG_FWD_DELAY, 32'd2);
		write_reg(CFG_TOPO, 32'd1);
		send_cmd(CMD_LEARN, mac_pool[10], 8'd2);
		send_cmd(CMD_TICK, 48'd0, 8'd0);
		send_cmd(CMD_LOOKUP, mac_pool[10], 8'd0);
		send_cmd(CMD_TICK, 48'd0, 8'd0);
		send_cmd(CMD_LOOKUP, mac_pool[10], 8'd0);
		send_cmd(CMD_LEARN, mac_pool[10], 8'd3);
		send_cmd(CMD_SWEEP, 48'd0, 8'd0);
		drain();
		random_phase(150);
		drain();

		// zero hold: learns are ignored
		write_reg(CFG_FWD_DELAY, 32'd0);
		random_phase(80);
		drain();

		// maximum hold, long receiver hold-off while the sender keeps going
		write_reg(CFG_TOPO, 32'd0);
		write_reg(CFG_AGEING, 32'hFFFF_FFFF);
		write_reg(CFG_FWD_DELAY, 32'hFFFF_FFFF);
		hold_cycles = 400;
		random_phase(120);
		drain();

		// no idling at all, with hold that wraps
		write_reg(CFG_AGEING, 32'h8000_0001);
		rx_mode = 1;
		tx_quiet = 1;
		random_phase(150);
		drain();

		rx_mode = 0;
		tx_quiet = 0;
		write_reg(CFG_AGEING, 32'd5);
		write_reg(CFG_TOPO, 32'd0);
		random_phase(130);
		drain();

		if (fail_count == 0 && pending == 0)
			$display("** mac_learning_table_core: PASSED **");
		else
			$display("** mac_learning_table_core: FAILED **");
		$finish;
	end

	initial begin
		#30ms;
		$display("** mac_learning_table_core: FAILED **");
		$finish;
	end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/mlt_pkg.sv
rtl/mlt_row_ram.sv
rtl/mac_learning_table_core.sv
sim/mac_table_checker.sv
sim/tb_mac_learning_table_core.sv
